@@ src/mm_pkg.sv @@
// mm_pkg: shared types and constants of the fixed-point matrix multiply block.
// No dependencies; used by every module under src.
package mm_pkg;

  localparam int unsigned ELEM_W = 16;  // Q8.8 operand
  localparam int unsigned PROD_W = 32;  // Q16.16 product
  localparam int unsigned VAL_W  = 38;  // Q22.16 sum
  localparam int unsigned IDX_W  = 4;   // row / col port width
  localparam int unsigned DIM_W  = 5;   // size register width

  typedef enum logic [1:0] {
    CMD_WR_A = 2'd0,
    CMD_WR_B = 2'd1,
    CMD_COMP = 2'd2,
    CMD_RD_C = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_ROWS_A    = 2'd0,
    CFG_INNER_DIM = 2'd1,
    CFG_COLS_B    = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE,
    ST_RD_OUT
  } state_e;

  // controller -> datapath commands
  typedef struct packed {
    logic wr_a;       // store value into A
    logic wr_b;       // store value into B
    logic mac_en;     // issue one multiply-accumulate
    logic mac_first;  // first term of a C element
    logic mac_last;   // last term, write C
    logic rd_c;       // read C element for a read item
    logic rd_zero;    // read returns zero
    logic cmpl;       // load completion result
  } mm_ctrl_t;

  // datapath -> controller status
  typedef struct packed {
    logic pipe_busy;  // MAC pipeline still holds work
  } mm_stat_t;

endpackage

@@ src/mm_datapath.sv @@
// mm_datapath: A/B/C element memories, MAC pipeline and result registers.
// Depends on mm_pkg; driven by mm_controller.
module mm_datapath #(
  parameter int unsigned MAX_DIM = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mm_pkg::mm_ctrl_t                  ctrl_i,
  output mm_pkg::mm_stat_t                  stat_o,
  input  logic [mm_pkg::IDX_W-1:0]          row_i,
  input  logic [mm_pkg::IDX_W-1:0]          col_i,
  input  logic signed [mm_pkg::ELEM_W-1:0]  value_i,
  input  logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] i_i,
  input  logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] j_i,
  input  logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] k_i,
  output logic signed [mm_pkg::VAL_W-1:0]   result_value_o,
  output logic [mm_pkg::IDX_W-1:0]          result_row_o,
  output logic [mm_pkg::IDX_W-1:0]          result_col_o,
  output logic                              is_completion_o
);

  localparam int unsigned DW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned XW    = (DW > mm_pkg::DIM_W) ? DW : mm_pkg::DIM_W;
  localparam int unsigned AW    = 2 * DW;
  localparam int unsigned DEPTH = 1 << AW;

  logic signed [mm_pkg::ELEM_W-1:0] a_mem [DEPTH];
  logic signed [mm_pkg::ELEM_W-1:0] b_mem [DEPTH];
  logic signed [mm_pkg::VAL_W-1:0]  c_mem [DEPTH];

  logic [XW-1:0] row_x, col_x;
  logic [AW-1:0] port_addr;

  assign row_x     = XW'(row_i);
  assign col_x     = XW'(col_i);
  assign port_addr = {row_x[DW-1:0], col_x[DW-1:0]};

  // stage 1: operand reads
  logic signed [mm_pkg::ELEM_W-1:0] a_q, b_q;
  logic                             v1_q, f1_q, l1_q;
  logic [AW-1:0]                    ca1_q;
  // stage 2: product
  logic signed [mm_pkg::PROD_W-1:0] prod_q;
  logic                             v2_q, f2_q, l2_q;
  logic [AW-1:0]                    ca2_q;
  // stage 3: accumulate
  logic signed [mm_pkg::VAL_W-1:0]  acc_q, acc_d;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_a) begin
      a_mem[port_addr] <= value_i;
    end
    if (ctrl_i.wr_b) begin
      b_mem[port_addr] <= value_i;
    end
    a_q <= a_mem[{i_i, k_i}];
    b_q <= b_mem[{k_i, j_i}];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= ctrl_i.mac_en;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f1_q   <= ctrl_i.mac_first;
    l1_q   <= ctrl_i.mac_last;
    ca1_q  <= {i_i, j_i};
    prod_q <= a_q * b_q;
    f2_q   <= f1_q;
    l2_q   <= l1_q;
    ca2_q  <= ca1_q;
  end

  assign acc_d = (f2_q ? '0 : acc_q) + mm_pkg::VAL_W'(prod_q);

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      acc_q <= acc_d;
      if (l2_q) begin
        c_mem[ca2_q] <= acc_d;
      end
    end
  end

  assign stat_o.pipe_busy = v1_q | v2_q;

  // result registers
  logic signed [mm_pkg::VAL_W-1:0] c_rd_q;
  logic                            zero_q, cmpl_q;
  logic [mm_pkg::IDX_W-1:0]        res_row_q, res_col_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_c) begin
      c_rd_q    <= c_mem[port_addr];
      zero_q    <= ctrl_i.rd_zero;
      res_row_q <= row_i;
      res_col_q <= col_i;
      cmpl_q    <= 1'b0;
    end else if (ctrl_i.cmpl) begin
      zero_q    <= 1'b1;
      res_row_q <= '0;
      res_col_q <= '0;
      cmpl_q    <= 1'b1;
    end
  end

  assign result_value_o  = zero_q ? '0 : c_rd_q;
  assign result_row_o    = res_row_q;
  assign result_col_o    = res_col_q;
  assign is_completion_o = cmpl_q;

endmodule

@@ src/mm_controller.sv @@
// mm_controller: size registers, command decode and the i/j/k loop sequencer.
// Depends on mm_pkg; commands mm_datapath through mm_ctrl_t.
module mm_controller #(
  parameter int unsigned MAX_DIM = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [1:0]                   command_i,
  input  logic [mm_pkg::IDX_W-1:0]     row_i,
  input  logic [mm_pkg::IDX_W-1:0]     col_i,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [mm_pkg::DIM_W-1:0]     cfg_data_i,
  input  mm_pkg::mm_stat_t             stat_i,
  output mm_pkg::mm_ctrl_t             ctrl_o,
  output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] i_o,
  output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] j_o,
  output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] k_o,
  output logic                         busy_o,
  output logic                         valid_o
);

  localparam int unsigned DW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  // wide enough for MAX_DIM itself and for a size register
  localparam int unsigned XW = ((DW + 1) > mm_pkg::DIM_W) ? (DW + 1) : mm_pkg::DIM_W;

  // size registers
  logic [mm_pkg::DIM_W-1:0] rows_a_q, inner_dim_q, cols_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= mm_pkg::DIM_W'(16);
      inner_dim_q <= mm_pkg::DIM_W'(16);
      cols_b_q    <= mm_pkg::DIM_W'(16);
    end else if (cfg_we_i) begin
      case (mm_pkg::cfg_reg_e'(cfg_idx_i))
        mm_pkg::CFG_ROWS_A:    rows_a_q    <= cfg_data_i;
        mm_pkg::CFG_INNER_DIM: inner_dim_q <= cfg_data_i;
        mm_pkg::CFG_COLS_B:    cols_b_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sizes saturated to the store
  logic [XW-1:0] n_clamp, m_clamp, p_clamp;
  assign n_clamp = (XW'(rows_a_q) > XW'(MAX_DIM))    ? XW'(MAX_DIM) : XW'(rows_a_q);
  assign m_clamp = (XW'(inner_dim_q) > XW'(MAX_DIM)) ? XW'(MAX_DIM) : XW'(inner_dim_q);
  assign p_clamp = (XW'(cols_b_q) > XW'(MAX_DIM))    ? XW'(MAX_DIM) : XW'(cols_b_q);

  mm_pkg::state_e state_q, state_d;
  logic [XW-1:0]  n_q, n_d, m_q, m_d, p_q, p_d;  // n/p also bound the valid part of C
  logic [DW-1:0]  i_q, i_d, j_q, j_d, k_q, k_d;

  logic in_store, accept, k_last, j_last, i_last;

  assign in_store = (XW'(row_i) < XW'(MAX_DIM)) && (XW'(col_i) < XW'(MAX_DIM));
  assign accept   = start_i && (state_q == mm_pkg::ST_IDLE);
  assign k_last   = (XW'(k_q) == m_q - XW'(1));
  assign j_last   = (XW'(j_q) == p_q - XW'(1));
  assign i_last   = (XW'(i_q) == n_q - XW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mm_pkg::ST_IDLE;
      n_q     <= '0;
      m_q     <= '0;
      p_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      m_q     <= m_d;
      p_q     <= p_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    m_d     = m_q;
    p_d     = p_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    ctrl_o  = '0;
    valid_o = 1'b0;

    case (state_q)
      mm_pkg::ST_IDLE: begin
        if (accept) begin
          case (mm_pkg::cmd_e'(command_i))
            mm_pkg::CMD_WR_A: ctrl_o.wr_a = in_store;
            mm_pkg::CMD_WR_B: ctrl_o.wr_b = in_store;
            mm_pkg::CMD_COMP: begin
              i_d = '0;
              j_d = '0;
              k_d = '0;
              m_d = m_clamp;
              if (n_clamp == '0 || m_clamp == '0 || p_clamp == '0) begin
                // empty product: C reads as all zeros
                n_d         = '0;
                p_d         = '0;
                ctrl_o.cmpl = 1'b1;
                state_d     = mm_pkg::ST_DONE;
              end else begin
                n_d     = n_clamp;
                p_d     = p_clamp;
                state_d = mm_pkg::ST_RUN;
              end
            end
            mm_pkg::CMD_RD_C: begin
              ctrl_o.rd_c    = 1'b1;
              ctrl_o.rd_zero = !in_store || (XW'(row_i) >= n_q) || (XW'(col_i) >= p_q);
              state_d        = mm_pkg::ST_RD_OUT;
            end
            default: ;
          endcase
        end
      end

      mm_pkg::ST_RUN: begin
        ctrl_o.mac_en    = 1'b1;
        ctrl_o.mac_first = (k_q == '0);
        ctrl_o.mac_last  = k_last;
        if (!k_last) begin
          k_d = k_q + DW'(1);
        end else begin
          k_d = '0;
          if (!j_last) begin
            j_d = j_q + DW'(1);
          end else begin
            j_d = '0;
            if (!i_last) begin
              i_d = i_q + DW'(1);
            end else begin
              state_d = mm_pkg::ST_DRAIN;
            end
          end
        end
      end

      mm_pkg::ST_DRAIN: begin
        if (!stat_i.pipe_busy) begin
          ctrl_o.cmpl = 1'b1;
          state_d     = mm_pkg::ST_DONE;
        end
      end

      mm_pkg::ST_DONE: begin
        valid_o = 1'b1;
        state_d = mm_pkg::ST_IDLE;
      end

      mm_pkg::ST_RD_OUT: begin
        valid_o = 1'b1;
        state_d = mm_pkg::ST_IDLE;
      end

      default: state_d = mm_pkg::ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != mm_pkg::ST_IDLE);
  assign i_o    = i_q;
  assign j_o    = j_q;
  assign k_o    = k_q;

endmodule

@@ src/matrix_multiply_top.sv @@
// Throughput: one item at a time, results cannot stall. Write A/B: no result, back to back.
// Read C: result strobe (valid_o) in the cycle after acceptance; next item once it ends.
// Compute: completion strobe once the single multiply-accumulate unit has taken all
// n*m*p terms (n, m, p = sizes saturated to MAX_DIM), one term per cycle, and its
// three-stage pipeline has drained; an empty product completes in the next cycle.
// Reset (rst_ni, async low): sizes 16/16/16, C reads as zero, A/B contents undefined.
//
// Top level of the fixed-point matrix multiply block (C = A * B, Q8.8 in, Q22.16 out).
// Depends on mm_pkg, mm_controller and mm_datapath.
module matrix_multiply_top #(
  parameter int unsigned MAX_DIM = 16  // store is MAX_DIM x MAX_DIM, 1..64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // item channel
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [1:0]                        command_i,
  input  logic [mm_pkg::IDX_W-1:0]          row_i,
  input  logic [mm_pkg::IDX_W-1:0]          col_i,
  input  logic signed [mm_pkg::ELEM_W-1:0]  value_i,
  // result channel, one-cycle strobe
  output logic                              valid_o,
  output logic signed [mm_pkg::VAL_W-1:0]   result_value_o,
  output logic [mm_pkg::IDX_W-1:0]          result_row_o,
  output logic [mm_pkg::IDX_W-1:0]          result_col_o,
  output logic                              is_completion_o,
  // size registers: 0 rows_a, 1 inner_dim, 2 cols_b
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_idx_i,
  input  logic [mm_pkg::DIM_W-1:0]          cfg_data_i
);

  localparam int unsigned DW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  mm_pkg::mm_ctrl_t ctrl;
  mm_pkg::mm_stat_t stat;
  logic [DW-1:0]    loop_i, loop_j, loop_k;

  // Controller: decodes items, holds the sizes and walks i, j, k (k innermost)
  // so each C element is summed in one accumulator and written once.
  mm_controller #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .command_i  (command_i),
    .row_i      (row_i),
    .col_i      (col_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl),
    .i_o        (loop_i),
    .j_o        (loop_j),
    .k_o        (loop_k),
    .busy_o     (busy_o),
    .valid_o    (valid_o)
  );

  // Datapath: operand memories, read -> multiply -> accumulate pipeline, C memory.
  // C entries outside the last computed size read as zero (tracked by the controller),
  // so C needs no clearing pass.
  mm_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .row_i           (row_i),
    .col_i           (col_i),
    .value_i         (value_i),
    .i_i             (loop_i),
    .j_i             (loop_j),
    .k_i             (loop_k),
    .result_value_o  (result_value_o),
    .result_row_o    (result_row_o),
    .result_col_o    (result_col_o),
    .is_completion_o (is_completion_o)
  );

endmodule

@@ src/mm_checker.sv @@
// mm_checker: port-level assertions for matrix_multiply_top, attached by bind.
// Depends on mm_pkg.
module mm_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start_i,
  input logic                             busy_o,
  input logic [1:0]                       command_i,
  input logic [mm_pkg::IDX_W-1:0]         row_i,
  input logic [mm_pkg::IDX_W-1:0]         col_i,
  input logic                             valid_o,
  input logic signed [mm_pkg::VAL_W-1:0]  result_value_o,
  input logic [mm_pkg::IDX_W-1:0]         result_row_o,
  input logic [mm_pkg::IDX_W-1:0]         result_col_o,
  input logic                             is_completion_o
);

  // a read item answers in the next cycle with its own indices
  a_read_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && command_i == mm_pkg::CMD_RD_C) |=>
      (valid_o && !is_completion_o && result_row_o == $past(row_i) &&
       result_col_o == $past(col_i)))
    else $error("read item not answered with its indices");

  // write items never produce a result
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (command_i == mm_pkg::CMD_WR_A || command_i == mm_pkg::CMD_WR_B))
      |=> !valid_o)
    else $error("result after write item");

  // completion carries all-zero payload
  a_cmpl_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && is_completion_o) |->
      (result_value_o == '0 && result_row_o == '0 && result_col_o == '0))
    else $error("completion with nonzero payload");

  // one result per item: strobe lasts a single cycle and only while busy
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (busy_o ##1 !valid_o))
    else $error("result strobe repeated or outside an item");

endmodule

bind matrix_multiply_top mm_checker u_mm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .command_i       (command_i),
  .row_i           (row_i),
  .col_i           (col_i),
  .valid_o         (valid_o),
  .result_value_o  (result_value_o),
  .result_row_o    (result_row_o),
  .result_col_o    (result_col_o),
  .is_completion_o (is_completion_o)
);
